FILE: design/delta_list_task_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// delta list task scheduler: assertion macros
// clocked checks on the scheduler's own logic, switched off by ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define DELTA_LIST_TASK_SCHEDULER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// check that is held off while reset is asserted
`define DLTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also runs during reset
`define DLTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DLTS_ASSERT(lbl, prop, msg)
`define DLTS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: design/dlts_pkg.sv
// ----------------------------------------------------------------------------
// dlts_pkg
// types, codes and field widths shared by the delta list task scheduler
// ----------------------------------------------------------------------------
package dlts_pkg;

  // field widths of the transfer payloads
  localparam int unsigned OP_FIELD_W    = 2;
  localparam int unsigned TASK_FIELD_W  = 8;
  localparam int unsigned DELAY_FIELD_W = 16;
  localparam int unsigned STAT_FIELD_W  = 2;
  localparam int unsigned COUNT_FIELD_W = 5;

  // pending run counter of the head, saturating
  localparam int unsigned RUNS_W = 8;
  localparam logic [RUNS_W-1:0] RUNS_MAX = 8'hFF;

  // operation codes
  localparam logic [OP_FIELD_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_FIELD_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OP_FIELD_W-1:0] OP_DISPATCH = 2'd2;

  // status codes
  localparam logic [STAT_FIELD_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_FIELD_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_FIELD_W-1:0] STATUS_EMPTY = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SHIFT,
    S_NEW,
    S_TICK,
    S_DISP,
    S_DONE
  } state_t;

  // input item
  typedef struct packed {
    logic [OP_FIELD_W-1:0]    op;
    logic [TASK_FIELD_W-1:0]  task_id;
    logic [DELAY_FIELD_W-1:0] delay_ticks;
    logic [DELAY_FIELD_W-1:0] period_ticks;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                     dispatched_valid;
    logic [TASK_FIELD_W-1:0]  dispatched_task;
    logic [STAT_FIELD_W-1:0]  status;
    logic [COUNT_FIELD_W-1:0] queue_count;
  } out_item_t;

endpackage

FILE: design/dlts_ram.sv
// ----------------------------------------------------------------------------
// dlts_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dlts_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/delta_list_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_unit: timer queue kept as a delta list in one RAM
// full, empty and unused-op replies go out straight from idle; a tick passes
// S_TICK, a one-shot dispatch S_DISP and an add to an empty queue S_NEW, then
// S_DONE; an insert walks the list (S_WALK), shifts the tail (S_SHIFT) and writes
// the entry (S_NEW), a tail append skips the shift; a periodic dispatch reinserts
// after S_DISP; one item at a time, set by the RAM walk and tail shift
// reset: synchronous, empties the queue; entries need no clearing pass
// ----------------------------------------------------------------------------
`include "delta_list_task_scheduler_unit_defines.svh"

module delta_list_task_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned DELAY_WIDTH = 16,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dlts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dlts_pkg::out_item_t  out_data
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = DELAY_WIDTH + AW;
  localparam int unsigned MW = ID_WIDTH + 2 * DELAY_WIDTH;

  // physical slot of a list position, the list is a ring starting at base
  function automatic logic [AW-1:0] slot(logic [AW-1:0] b, logic [AW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, i};
    if (s >= (AW + 1)'(QUEUE_DEPTH)) begin
      s = s - (AW + 1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dlts_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 base_r, base_nxt;
  logic [dlts_pkg::RUNS_W-1:0]   runs_r, runs_nxt;
  logic [dlts_pkg::RUNS_W-1:0]   left_r, left_nxt;
  logic                          reinsert_r, reinsert_nxt;
  logic [AW-1:0]                 j_r, j_nxt;
  logic [AW-1:0]                 pos_r, pos_nxt;
  logic                          append_r, append_nxt;
  logic [AW-1:0]                 sh_idx_r, sh_idx_nxt;
  logic                          rd_go_r, rd_go_nxt;
  logic                          wb_v_r, wb_v_nxt;
  logic [AW-1:0]                 wb_idx_r, wb_idx_nxt;
  logic [SW-1:0]                 sum_r, sum_nxt;
  logic [SW-1:0]                 pre_r, pre_nxt;
  logic [DELAY_WIDTH-1:0]        eff_r, eff_nxt;
  logic [ID_WIDTH-1:0]           new_id_r, new_id_nxt;
  logic [DELAY_WIDTH-1:0]        new_delay_r, new_delay_nxt;
  logic [DELAY_WIDTH-1:0]        new_period_r, new_period_nxt;
  dlts_pkg::out_item_t           res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dlts_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [MW-1:0]                 mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [MW-1:0]                 mem_rdata;

  logic [ID_WIDTH-1:0]           rd_task;
  logic [DELAY_WIDTH-1:0]        rd_delta;
  logic [DELAY_WIDTH-1:0]        rd_period;
  logic                          out_free;
  logic                          walk_first;
  logic [DELAY_WIDTH-1:0]        eff_now;
  logic [SW-1:0]                 s_new;
  logic                          walk_hold;
  logic                          walk_last;

  // entry store: task id, delta, period per slot
  dlts_ram #(
    .WIDTH (MW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_task   = mem_rdata[MW-1 -: ID_WIDTH];
  assign rd_delta  = mem_rdata[2*DELAY_WIDTH-1 -: DELAY_WIDTH];
  assign rd_period = mem_rdata[DELAY_WIDTH-1:0];

  // handshake
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == dlts_pkg::S_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // one step of the insertion walk over the delta list
  always_comb begin
    walk_first = (j_r == '0);
    if (walk_first) begin
      eff_now = ((runs_r != '0) && (new_delay_r < rd_delta)) ? rd_delta : new_delay_r;
    end else begin
      eff_now = eff_r;
    end
    s_new     = sum_r + SW'(rd_delta);
    walk_hold = (SW'(eff_now) > s_new) || (walk_first && (runs_r != '0));
    walk_last = ((CW'(j_r) + CW'(1)) == count_r);
  end

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    base_nxt       = base_r;
    runs_nxt       = runs_r;
    left_nxt       = left_r;
    reinsert_nxt   = reinsert_r;
    j_nxt          = j_r;
    pos_nxt        = pos_r;
    append_nxt     = append_r;
    sh_idx_nxt     = sh_idx_r;
    rd_go_nxt      = rd_go_r;
    wb_v_nxt       = wb_v_r;
    wb_idx_nxt     = wb_idx_r;
    sum_nxt        = sum_r;
    pre_nxt        = pre_r;
    eff_nxt        = eff_r;
    new_id_nxt     = new_id_r;
    new_delay_nxt  = new_delay_r;
    new_period_nxt = new_period_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = base_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = base_r;

    unique case (state_r)
      dlts_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          new_id_nxt                = ID_WIDTH'(in_data.task_id);
          new_delay_nxt             = DELAY_WIDTH'(in_data.delay_ticks);
          new_period_nxt            = DELAY_WIDTH'(in_data.period_ticks);
          reinsert_nxt              = 1'b0;
          res_nxt.dispatched_valid  = 1'b0;
          res_nxt.dispatched_task   = '0;
          res_nxt.status            = dlts_pkg::STATUS_OK;
          res_nxt.queue_count       = dlts_pkg::COUNT_FIELD_W'(count_r);
          unique case (in_data.op)
            dlts_pkg::OP_ADD: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                res_nxt.status = dlts_pkg::STATUS_FULL;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = res_nxt;
              end else if (count_r == '0) begin
                pos_nxt    = '0;
                pre_nxt    = '0;
                append_nxt = 1'b0;
                eff_nxt    = DELAY_WIDTH'(in_data.delay_ticks);
                state_nxt  = dlts_pkg::S_NEW;
              end else begin
                // head is being read, walk starts next cycle
                j_nxt     = '0;
                sum_nxt   = '0;
                pre_nxt   = '0;
                state_nxt = dlts_pkg::S_WALK;
              end
            end
            dlts_pkg::OP_TICK: begin
              if (count_r == '0) begin
                res_nxt.status = dlts_pkg::STATUS_EMPTY;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = res_nxt;
              end else begin
                state_nxt = dlts_pkg::S_TICK;
              end
            end
            dlts_pkg::OP_DISPATCH: begin
              if ((count_r == '0) || (runs_r == '0)) begin
                res_nxt.status = dlts_pkg::STATUS_EMPTY;
                out_valid_nxt  = 1'b1;
                out_data_nxt   = res_nxt;
              end else begin
                state_nxt = dlts_pkg::S_DISP;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = res_nxt;
            end
          endcase
        end
      end

      dlts_pkg::S_WALK: begin
        // fetch the next position ahead of the decision
        mem_raddr = slot(base_r, j_r + AW'(1));
        eff_nxt   = eff_now;
        sum_nxt   = s_new;
        if (!walk_hold) begin
          pos_nxt    = j_r;
          pre_nxt    = sum_r;
          append_nxt = 1'b0;
          sh_idx_nxt = AW'(count_r - CW'(1));
          rd_go_nxt  = 1'b1;
          wb_v_nxt   = 1'b0;
          state_nxt  = dlts_pkg::S_SHIFT;
        end else if (walk_last) begin
          pos_nxt    = AW'(count_r);
          append_nxt = 1'b1;
          state_nxt  = dlts_pkg::S_NEW;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end

      dlts_pkg::S_SHIFT: begin
        // move the tail up by one, last entry first
        mem_raddr = slot(base_r, sh_idx_r);
        mem_we    = wb_v_r;
        mem_waddr = slot(base_r, wb_idx_r + AW'(1));
        if (wb_idx_r == pos_r) begin
          // old occupant of the insert position follows the new entry
          mem_wdata = {rd_task, DELAY_WIDTH'(sum_r - SW'(eff_r)), rd_period};
        end else begin
          mem_wdata = mem_rdata;
        end
        if (rd_go_r) begin
          wb_v_nxt   = 1'b1;
          wb_idx_nxt = sh_idx_r;
          if (sh_idx_r == pos_r) begin
            rd_go_nxt = 1'b0;
          end else begin
            sh_idx_nxt = sh_idx_r - AW'(1);
          end
        end else begin
          wb_v_nxt = 1'b0;
          if (wb_v_r) begin
            state_nxt = dlts_pkg::S_NEW;
          end
        end
      end

      dlts_pkg::S_NEW: begin
        // place the new entry
        mem_we    = 1'b1;
        mem_waddr = slot(base_r, pos_r);
        if (append_r) begin
          mem_wdata = {new_id_r, DELAY_WIDTH'(SW'(eff_r) - sum_r), new_period_r};
        end else begin
          mem_wdata = {new_id_r, DELAY_WIDTH'(SW'(eff_r) - pre_r), new_period_r};
        end
        count_nxt           = count_r + CW'(1);
        res_nxt.queue_count = dlts_pkg::COUNT_FIELD_W'(count_r + CW'(1));
        if (reinsert_r) begin
          runs_nxt = (pos_r == '0) ? left_r : '0;
        end
        state_nxt = dlts_pkg::S_DONE;
      end

      dlts_pkg::S_TICK: begin
        // count down the head, or count a run and reload the period
        mem_we    = 1'b1;
        mem_waddr = base_r;
        if (rd_delta == '0) begin
          mem_wdata = {rd_task, rd_period, rd_period};
          if (runs_r != dlts_pkg::RUNS_MAX) begin
            runs_nxt = runs_r + dlts_pkg::RUNS_W'(1);
          end
        end else begin
          mem_wdata = {rd_task, rd_delta - DELAY_WIDTH'(1), rd_period};
        end
        state_nxt = dlts_pkg::S_DONE;
      end

      dlts_pkg::S_DISP: begin
        // pop the head by moving the ring base
        res_nxt.dispatched_valid = 1'b1;
        res_nxt.dispatched_task  = dlts_pkg::TASK_FIELD_W'(rd_task);
        res_nxt.queue_count      = dlts_pkg::COUNT_FIELD_W'(count_r - CW'(1));
        runs_nxt                 = '0;
        left_nxt                 = runs_r - dlts_pkg::RUNS_W'(1);
        count_nxt                = count_r - CW'(1);
        base_nxt                 = slot(base_r, AW'(1));
        if (rd_period != '0) begin
          // periodic task goes back in with its remaining delay
          new_id_nxt     = rd_task;
          new_delay_nxt  = rd_delta;
          new_period_nxt = rd_period;
          reinsert_nxt   = 1'b1;
          eff_nxt        = rd_delta;
          pre_nxt        = '0;
          if (count_r == CW'(1)) begin
            pos_nxt    = '0;
            append_nxt = 1'b0;
            state_nxt  = dlts_pkg::S_NEW;
          end else begin
            mem_raddr = slot(base_r, AW'(1));
            j_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = dlts_pkg::S_WALK;
          end
        end else begin
          state_nxt = dlts_pkg::S_DONE;
        end
      end

      dlts_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = dlts_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = dlts_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlts_pkg::S_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      runs_r      <= '0;
      reinsert_r  <= 1'b0;
      rd_go_r     <= 1'b0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      runs_r      <= runs_nxt;
      reinsert_r  <= reinsert_nxt;
      rd_go_r     <= rd_go_nxt;
      wb_v_r      <= wb_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    left_r       <= left_nxt;
    j_r          <= j_nxt;
    pos_r        <= pos_nxt;
    append_r     <= append_nxt;
    sh_idx_r     <= sh_idx_nxt;
    wb_idx_r     <= wb_idx_nxt;
    sum_r        <= sum_nxt;
    pre_r        <= pre_nxt;
    eff_r        <= eff_nxt;
    new_id_r     <= new_id_nxt;
    new_delay_r  <= new_delay_nxt;
    new_period_r <= new_period_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  // checks
  `DLTS_ASSERT(a_count_bound, count_r <= CW'(QUEUE_DEPTH), "queue count beyond depth")
  `DLTS_ASSERT(a_runs_need_head, (runs_r != '0) |-> (count_r != '0), "runs on empty queue")
  `DLTS_ASSERT(a_full_add,
    (in_valid && in_ready && (in_data.op == dlts_pkg::OP_ADD) && (count_r == CW'(QUEUE_DEPTH)))
      |=> (out_valid_r && (out_data_r.status == dlts_pkg::STATUS_FULL)),
    "add on full queue not flagged")
  `DLTS_ASSERT(a_shift_range,
    ((state_r == dlts_pkg::S_SHIFT) && rd_go_r) |-> (sh_idx_r >= pos_r),
    "tail shift past insert position")

endmodule
